// ----- src/tpst_pkg.sv -----
// Shared types and constants of the touch press, hold and swipe tracker.
`default_nettype none
package tpst_pkg;

  // Coordinate width used inside the tracker
  localparam int COORD_W = 12;

  // Hold counter restarts once it passes this value
  localparam logic [15:0] HOLD_WRAP = 16'd64999;

  // Configuration register indexes
  localparam logic [2:0] CFG_PRESS_DELAY   = 3'd0;
  localparam logic [2:0] CFG_HOLD_DELAY    = 3'd1;
  localparam logic [2:0] CFG_REPEAT_PERIOD = 3'd2;
  localparam logic [2:0] CFG_STILL_LIMIT   = 3'd3;
  localparam logic [2:0] CFG_SLIDE_LIMIT   = 3'd4;

  // Reset values of the configuration registers
  localparam logic [15:0] PRESS_DELAY_RST   = 16'd3;
  localparam logic [15:0] HOLD_DELAY_RST    = 16'd50;
  localparam logic [15:0] REPEAT_PERIOD_RST = 16'd10;
  localparam logic [11:0] STILL_LIMIT_RST   = 12'd3;
  localparam logic [11:0] SLIDE_LIMIT_RST   = 12'd20;

  typedef enum logic [3:0] {
    EV_DOWN       = 4'd0,
    EV_HOLD       = 4'd1,
    EV_REPEAT     = 4'd2,
    EV_UP_BEFORE  = 4'd3,
    EV_UP_AFTER   = 4'd4,
    EV_LEFT       = 4'd5,
    EV_RIGHT      = 4'd6,
    EV_UP         = 4'd7,
    EV_SWIPE_DOWN = 4'd8
  } event_t;

  typedef struct packed {
    event_t      event_code;
    logic [11:0] event_x;
    logic [11:0] event_y;
    logic        last_of_run;
  } result_t;

  // Results of one processed sample, pushed into the result queue
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage
`default_nettype wire

// ----- src/tpst_in_if.sv -----
// Sample channel: valid/ready handshake with point count and coordinates.
`default_nettype none
interface tpst_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  point_count;
  logic [11:0] x_pos;
  logic [11:0] y_pos;

  modport source (output valid, output point_count, output x_pos, output y_pos,
                  input ready);
  modport sink (input valid, input point_count, input x_pos, input y_pos,
                output ready);
endinterface
`default_nettype wire

// ----- src/tpst_out_if.sv -----
// Event channel: valid/ready handshake with one event per transfer.
`default_nettype none
interface tpst_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_code;
  logic [11:0] event_x;
  logic [11:0] event_y;
  logic        last_of_run;

  modport source (output valid, output event_code, output event_x, output event_y,
                  output last_of_run, input ready);
  modport sink (input valid, input event_code, input event_x, input event_y,
                input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- src/tpst_core.sv -----
// Sample register, configuration registers, tracking state and event logic.
`default_nettype none
module tpst_core
  import tpst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  tpst_in_if.sink          in_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic [1:0]  room,
  output push_t            push
);

  typedef enum logic [2:0] {
    KS_NONE,
    KS_DOWN,
    KS_HOLD,
    KS_REPEAT
  } key_t;

  // Sample register
  logic                s_valid_r;
  logic [3:0]          s_count_r;
  logic [COORD_W-1:0]  s_x_r, s_y_r;

  // Configuration
  logic [15:0] press_delay_r, hold_delay_r, repeat_period_r;
  logic [11:0] still_limit_r, slide_limit_r;

  // Tracking state
  key_t               key_r, key_nxt;
  logic               touching_r, touching_nxt;
  logic [15:0]        hold_cnt_r, hold_cnt_nxt;
  logic [15:0]        phase_r, phase_nxt;
  logic [COORD_W-1:0] start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic [COORD_W-1:0] last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic [COORD_W-1:0] shift_x_r, shift_x_nxt, shift_y_r, shift_y_nxt;

  logic        accept, fire;
  logic [1:0]  n;
  event_t      evs [2];
  logic [15:0] hc1, ph1;
  logic        multiple, still_now, still_old;

  assign accept      = in_ch.valid && in_ch.ready;
  assign fire        = s_valid_r && (n <= room);
  assign in_ch.ready = !s_valid_r || fire;

  // Work out the events of the held sample and the next state
  always_comb begin
    key_nxt      = key_r;
    touching_nxt = touching_r;
    hold_cnt_nxt = hold_cnt_r;
    phase_nxt    = phase_r;
    start_x_nxt  = start_x_r;
    start_y_nxt  = start_y_r;
    last_x_nxt   = last_x_r;
    last_y_nxt   = last_y_r;
    shift_x_nxt  = shift_x_r;
    shift_y_nxt  = shift_y_r;
    n            = 2'd0;
    evs[0]       = EV_DOWN;
    evs[1]       = EV_DOWN;
    hc1          = 16'd1;
    ph1          = 16'd1;
    multiple     = 1'b0;
    still_now    = 1'b0;
    still_old    = (12'(shift_x_r) < still_limit_r) && (12'(shift_y_r) < still_limit_r);

    if (s_count_r == 4'd1) begin
      if (!touching_r) begin
        touching_nxt = 1'b1;
        start_x_nxt  = s_x_r;
        start_y_nxt  = s_y_r;
      end
      last_x_nxt  = s_x_r;
      last_y_nxt  = s_y_r;
      shift_x_nxt = (start_x_nxt > s_x_r) ? start_x_nxt - s_x_r : s_x_r - start_x_nxt;
      shift_y_nxt = (start_y_nxt > s_y_r) ? start_y_nxt - s_y_r : s_y_r - start_y_nxt;

      // Restart both counters once the hold count passes its wrap point
      if (hold_cnt_r > HOLD_WRAP) begin
        hc1 = 16'd1;
        ph1 = 16'd1;
      end else begin
        hc1 = hold_cnt_r + 16'd1;
        ph1 = phase_r + 16'd1;
      end
      multiple     = ph1 >= repeat_period_r;
      hold_cnt_nxt = hc1;
      phase_nxt    = multiple ? 16'd0 : ph1;

      still_now = (12'(shift_x_nxt) < still_limit_r) && (12'(shift_y_nxt) < still_limit_r);
      if (still_now) begin
        if (hc1 >= press_delay_r && hc1 < hold_delay_r && key_nxt == KS_NONE) begin
          key_nxt     = KS_DOWN;
          evs[n[0]]   = EV_DOWN;
          n           = n + 2'd1;
        end
        if (hc1 >= hold_delay_r && key_nxt == KS_DOWN) begin
          key_nxt     = KS_HOLD;
          evs[n[0]]   = EV_HOLD;
          n           = n + 2'd1;
        end
        if (multiple && (key_nxt == KS_HOLD || key_nxt == KS_REPEAT)) begin
          key_nxt     = KS_REPEAT;
          evs[n[0]]   = EV_REPEAT;
          n           = n + 2'd1;
        end
      end
    end else if (s_count_r == 4'd0) begin
      // Release: classify the gesture from the last single-point sample
      if (touching_r) begin
        if (still_old) begin
          if (key_r == KS_DOWN) begin
            evs[0] = EV_UP_BEFORE;
            n      = 2'd1;
          end else if (key_r == KS_HOLD || key_r == KS_REPEAT) begin
            evs[0] = EV_UP_AFTER;
            n      = 2'd1;
          end
        end else if (shift_x_r > shift_y_r && 12'(shift_x_r) >= slide_limit_r) begin
          if (start_x_r > last_x_r) begin
            evs[0] = EV_LEFT;
            n      = 2'd1;
          end else if (start_x_r < last_x_r) begin
            evs[0] = EV_RIGHT;
            n      = 2'd1;
          end
        end else if (shift_x_r < shift_y_r && 12'(shift_y_r) >= slide_limit_r) begin
          if (start_y_r > last_y_r) begin
            evs[0] = EV_UP;
            n      = 2'd1;
          end else if (start_y_r < last_y_r) begin
            evs[0] = EV_SWIPE_DOWN;
            n      = 2'd1;
          end
        end
      end
      touching_nxt = 1'b0;
      key_nxt      = KS_NONE;
      hold_cnt_nxt = 16'd0;
      phase_nxt    = 16'd0;
      start_x_nxt  = '0;
      start_y_nxt  = '0;
    end
  end

  // Build the push toward the result queue
  always_comb begin
    push.n              = fire ? n : 2'd0;
    push.r0.event_code  = evs[0];
    push.r0.event_x     = 12'(last_x_nxt);
    push.r0.event_y     = 12'(last_y_nxt);
    push.r0.last_of_run = (n == 2'd1);
    push.r1.event_code  = evs[1];
    push.r1.event_x     = 12'(last_x_nxt);
    push.r1.event_y     = 12'(last_y_nxt);
    push.r1.last_of_run = 1'b1;
  end

  // Hold the sample until its events fit in the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (accept) begin
      s_valid_r <= 1'b1;
    end else if (fire) begin
      s_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_count_r <= in_ch.point_count;
      s_x_r     <= in_ch.x_pos[COORD_W-1:0];
      s_y_r     <= in_ch.y_pos[COORD_W-1:0];
    end
  end

  // Decode configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_delay_r   <= PRESS_DELAY_RST;
      hold_delay_r    <= HOLD_DELAY_RST;
      repeat_period_r <= REPEAT_PERIOD_RST;
      still_limit_r   <= STILL_LIMIT_RST;
      slide_limit_r   <= SLIDE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRESS_DELAY:   press_delay_r   <= cfg_data;
        CFG_HOLD_DELAY:    hold_delay_r    <= cfg_data;
        CFG_REPEAT_PERIOD: repeat_period_r <= cfg_data;
        CFG_STILL_LIMIT:   still_limit_r   <= cfg_data[11:0];
        CFG_SLIDE_LIMIT:   slide_limit_r   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Advance tracking state on each processed sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r      <= KS_NONE;
      touching_r <= 1'b0;
      hold_cnt_r <= 16'd0;
      phase_r    <= 16'd0;
      start_x_r  <= '0;
      start_y_r  <= '0;
      last_x_r   <= '0;
      last_y_r   <= '0;
      shift_x_r  <= '0;
      shift_y_r  <= '0;
    end else if (fire) begin
      key_r      <= key_nxt;
      touching_r <= touching_nxt;
      hold_cnt_r <= hold_cnt_nxt;
      phase_r    <= phase_nxt;
      start_x_r  <= start_x_nxt;
      start_y_r  <= start_y_nxt;
      last_x_r   <= last_x_nxt;
      last_y_r   <= last_y_nxt;
      shift_x_r  <= shift_x_nxt;
      shift_y_r  <= shift_y_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/tpst_queue.sv -----
// Two-entry result queue that takes up to two events a cycle.
`default_nettype none
module tpst_queue
  import tpst_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  push_t      push,
  output logic [1:0] room,
  tpst_out_if.source out_ch
);

  result_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       pop;
  result_t    head;

  assign head               = mem_r[rp_r];
  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.event_code  = head.event_code;
  assign out_ch.event_x     = head.event_x;
  assign out_ch.event_y     = head.event_y;
  assign out_ch.last_of_run = head.last_of_run;

  assign pop  = out_ch.valid && out_ch.ready;
  // Free entries, counting the transfer leaving this cycle
  assign room = 2'(2'd2 - cnt_r + {1'b0, pop});

  // Store pushed events
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wp_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[~wp_r] <= push.r1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_r ^ push.n[0];
      rp_r  <= rp_r ^ pop;
      cnt_r <= 2'(cnt_r + push.n - {1'b0, pop});
    end
  end

endmodule
`default_nettype wire

// ----- src/touch_press_hold_swipe_tracker.sv -----
// Top level of the touch press, hold and swipe tracker.
//
// The in_ch channel takes one touch-panel sample per transfer: point count
// and the first point's coordinates. The out_ch channel delivers events, one
// per transfer, with last_of_run set on the final event of a sample. The
// cfg_ port writes the five timing and distance registers; the user must
// write them only while idle, as the block itself does not enforce it.
//
// A sample transfer loads an input register; the next cycle the event logic
// runs on it. Once its events fit, the tracking state updates and they enter
// the result queue, which offers them on out_ch. Throughput is one sample
// per cycle while the queue has room; a sample that causes two events (hold
// with repeat) needs two output transfers, so those set the pace there. The
// two-entry result queue sets how far the sides can drift apart.
//
// Reset restores the register defaults, clears the tracking state and
// empties the queue. When the receiver stalls, the queue fills, the sample
// in the input register waits until its events fit, and in_ch.ready drops.
`default_nettype none
module touch_press_hold_swipe_tracker
  import tpst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  tpst_in_if.sink          in_ch,
  tpst_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  push_t      push;
  logic [1:0] room;

  tpst_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .room      (room),
    .push      (push)
  );

  tpst_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  // A push never overflows the queue
  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    push.n <= room)
    else $error("result push exceeds free queue entries");

  // A single event closes its run
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd1 |-> push.r0.last_of_run)
    else $error("single event without last_of_run");

  // Of a pair, only the second closes the run
  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> !push.r0.last_of_run && push.r1.last_of_run)
    else $error("event pair with wrong last_of_run marks");

  // Two events of one sample are always hold then repeat
  a_pair_codes: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> push.r0.event_code == EV_HOLD && push.r1.event_code == EV_REPEAT)
    else $error("unexpected event pair");
`endif

endmodule
`default_nettype wire
